>>> hw/rtl/ntis_pkg.sv
// ----------------------------------------------------------------------------
// ntis_pkg: shared types and constants
// Command and status codes, sequencer states, cell control and default sizes
// for the name table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntis_pkg;

  localparam int DEPTH_DEF    = 128;
  localparam int KEY_BITS_DEF = 64;
  localparam int GROUP        = 16;

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;
  localparam int FIELD8      = 8;
  localparam int OUT_BITS    = STATUS_BITS + 2 * FIELD8;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_BITS-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_CREATED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_FOUND     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_FIN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/name_table_insert_delete_search.sv
// ----------------------------------------------------------------------------
// name_table_insert_delete_search: table of unique keys in insertion order
// Create, delete and search over a row of key cells with a registered
// match tree and a small sequencer.
// ----------------------------------------------------------------------------
// Each item passes the states idle, compare, reduce, finish and execute:
// it is taken in idle, the cells compare the key in parallel, the match
// tree folds the flags over two registered levels, and execute writes the
// table and loads the result register. The next item is taken in the
// cycle after that. Execute waits while an earlier result has not been
// taken. Delete shifts every later cell down by one in that same cycle.
`default_nettype none

module name_table_insert_delete_search #(
  parameter int DEPTH    = ntis_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ntis_pkg::KEY_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  // cmd, key
  input  wire  [((KEY_BITS + ntis_pkg::CMD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  wire  m_tready,
  // status, position, entry_count
  output logic [ntis_pkg::OUT_W-1:0] m_tdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (CW > ntis_pkg::FIELD8) ? CW : ntis_pkg::FIELD8;

  ntis_pkg::state_t state, state_next;

  logic [ntis_pkg::CMD_BITS-1:0] cmd;
  logic [KEY_BITS-1:0]           key;
  logic [CW-1:0]                 count, count_next;

  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [KEY_BITS-1:0]   nbr_key  [DEPTH];
  ntis_pkg::cell_ctrl_t  cell_ctrl [DEPTH];
  logic [DEPTH-1:0]      match;
  logic [IW-1:0]         hit_idx;
  logic                  found;

  logic                  accept;
  logic                  out_free;
  logic                  exec_fire;
  logic                  full;
  ntis_pkg::status_t     status_next;
  logic [CW-1:0]         pos_next;
  logic [OW-1:0]         pos_ext;
  logic [OW-1:0]         cnt_ext;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_nbr
      assign nbr_key[i] = cell_key[i + 1];
    end else begin : g_top
      assign nbr_key[i] = '0;
    end

    always_comb begin
      cell_ctrl[i].load  = exec_fire && (cmd == ntis_pkg::CMD_CREATE) && !full &&
                           !found && (count == CW'(i));
      cell_ctrl[i].shift = exec_fire && (cmd == ntis_pkg::CMD_DELETE) && found &&
                           (hit_idx <= IW'(i));
    end

    ntis_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid   (CW'(i) < count),
      .cmp_key (key),
      .nbr_key (nbr_key[i]),
      .ctrl    (cell_ctrl[i]),
      .key     (cell_key[i]),
      .match   (match[i])
    );
  end

  ntis_reduce #(
    .DEPTH (DEPTH)
  ) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .match   (match),
    .hit_idx (hit_idx),
    .found   (found)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ntis_pkg::S_IDLE: if (s_tvalid) state_next = ntis_pkg::S_CMP;
      ntis_pkg::S_CMP:  state_next = ntis_pkg::S_RED;
      ntis_pkg::S_RED:  state_next = ntis_pkg::S_FIN;
      ntis_pkg::S_FIN:  state_next = ntis_pkg::S_EXEC;
      ntis_pkg::S_EXEC: if (out_free) state_next = ntis_pkg::S_IDLE;
      default:          state_next = ntis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ntis_pkg::S_IDLE);
    accept    = s_tvalid && s_tready;
    out_free  = !m_tvalid || m_tready;
    exec_fire = (state == ntis_pkg::S_EXEC) && out_free;
  end

  always_comb begin
    full        = (count >= CW'(DEPTH));
    count_next  = count;
    pos_next    = '0;
    status_next = ntis_pkg::ST_NOTFOUND;
    unique case (cmd)
      ntis_pkg::CMD_CREATE: begin
        if (full) begin
          status_next = ntis_pkg::ST_FULL;
        end else if (found) begin
          status_next = ntis_pkg::ST_DUPLICATE;
        end else begin
          status_next = ntis_pkg::ST_CREATED;
          count_next  = count + CW'(1);
        end
      end
      ntis_pkg::CMD_DELETE: begin
        if (found) begin
          status_next = ntis_pkg::ST_DELETED;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        if (found) begin
          status_next = ntis_pkg::ST_FOUND;
          pos_next    = CW'(hit_idx) + CW'(1);
        end
      end
    endcase
    pos_ext = OW'(pos_next);
    cnt_ext = OW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ntis_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= s_tdata[ntis_pkg::CMD_BITS-1:0];
      key <= s_tdata[KEY_BITS + ntis_pkg::CMD_BITS - 1:ntis_pkg::CMD_BITS];
    end
    if (exec_fire) begin
      m_tdata <= {{(ntis_pkg::OUT_W - ntis_pkg::OUT_BITS){1'b0}},
                  cnt_ext[ntis_pkg::FIELD8-1:0],
                  pos_ext[ntis_pkg::FIELD8-1:0],
                  status_next};
    end
  end

  a_rose_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ntis_pkg::S_EXEC)
    else $error("result raised outside the execute cycle");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ntis_pkg::S_EXEC) && found |-> CW'(hit_idx) < count)
    else $error("match reported beyond the filled entries");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    exec_fire && (status_next == ntis_pkg::ST_CREATED) |=>
      count == $past(count) + CW'(1))
    else $error("create did not advance the entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    exec_fire |-> count_next <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

endmodule

`default_nettype wire

>>> hw/rtl/ntis_cell.sv
// ----------------------------------------------------------------------------
// ntis_cell: one table slot
// Holds one key, compares it against the broadcast key and takes either a
// new key or the key of its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_cell #(
  parameter int KEY_BITS = ntis_pkg::KEY_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      valid,
  input  wire  [KEY_BITS-1:0]      cmp_key,
  input  wire  [KEY_BITS-1:0]      nbr_key,
  input  ntis_pkg::cell_ctrl_t     ctrl,
  output logic [KEY_BITS-1:0]      key,
  output logic                     match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= cmp_key;
    end else if (ctrl.shift) begin
      key <= nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= valid && (key == cmp_key);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ntis_reduce.sv
// ----------------------------------------------------------------------------
// ntis_reduce: registered match tree
// Folds the one-hot cell match flags into a hit flag and a slot index in two
// registered levels.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_reduce #(
  parameter int DEPTH = ntis_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  [DEPTH-1:0]             match,
  output logic [$clog2(DEPTH)-1:0]     hit_idx,
  output logic                         found
);

  localparam int IW = $clog2(DEPTH);
  localparam int NG = (DEPTH + ntis_pkg::GROUP - 1) / ntis_pkg::GROUP;

  logic [IW-1:0] grp_idx   [NG];
  logic [NG-1:0] grp_hit;
  logic [IW-1:0] grp_idx_c [NG];
  logic [NG-1:0] grp_hit_c;
  logic [IW-1:0] idx_c;
  logic          hit_c;

  always_comb begin
    int n;
    for (int g = 0; g < NG; g++) begin
      grp_idx_c[g] = '0;
      grp_hit_c[g] = 1'b0;
      for (int j = 0; j < ntis_pkg::GROUP; j++) begin
        n = g * ntis_pkg::GROUP + j;
        if (n < DEPTH) begin
          if (match[n]) begin
            grp_idx_c[g] = grp_idx_c[g] | IW'(n);
            grp_hit_c[g] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    idx_c = '0;
    for (int g = 0; g < NG; g++) begin
      idx_c = idx_c | grp_idx[g];
    end
    hit_c = |grp_hit;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_idx[g] <= grp_idx_c[g];
    end
    hit_idx <= idx_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_hit <= '0;
      found   <= 1'b0;
    end else begin
      grp_hit <= grp_hit_c;
      found   <= hit_c;
    end
  end

endmodule

`default_nettype wire
